FILE: src/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bilinear image resampler.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int unsigned MAX_SRC_W  = 256;
  localparam int unsigned MAX_SRC_H  = 256;
  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned W_BITS     = 7;
  localparam int unsigned FRAC_BITS  = 17;
  localparam int unsigned HALF_AW    = 7;
  localparam int unsigned BANK_AW    = 2 * HALF_AW;
  localparam int unsigned BANKS      = 4;

  localparam logic [8:0] MAX_SZ      = 9'd256;
  localparam logic [7:0] WGT_ONE     = 8'd128;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SCALE_X    = 3'd4,
    REG_SCALE_Y    = 3'd5,
    REG_INTERP     = 3'd6
  } cfg_reg_e;

  // per-axis result of coordinate mapping
  typedef struct packed {
    logic [7:0]        idx;
    logic              oor;
    logic              clamp;
    logic [7:0]        w1;
    logic [W_BITS-1:0] w2;
  } axis_t;

  // request state carried alongside the frame store read
  typedef struct packed {
    logic              ix0;
    logic              iy0;
    logic              clx;
    logic              cly;
    logic              oor;
    logic [7:0]        wx1;
    logic [W_BITS-1:0] wx2;
    logic [7:0]        wy1;
    logic [W_BITS-1:0] wy2;
  } meta_t;

endpackage

FILE: src/bir_axis.sv
// ----------------------------------------------------------------------------
// bir_axis
// Maps one destination coordinate into the source: index, range flag,
// edge clamp and blend weights. Two stages (multiply, then offset/index).
// ----------------------------------------------------------------------------
module bir_axis import bir_pkg::*; (
  input  logic        clk_i,
  input  logic        en1_i,
  input  logic        en2_i,
  input  logic [11:0] d_i,
  input  logic [12:0] dsize_i,
  input  logic [23:0] scale_i,
  input  logic [8:0]  ssize_i,
  input  logic        mode_i,
  output axis_t       axis_o
);

  logic signed [14:0] twice;
  logic signed [39:0] prod_d, prod_q;
  logic [8:0]         ssz;
  logic signed [40:0] v, t;
  logic [40:0]        tm;
  logic signed [24:0] fl, nq, idx, szs;
  logic [W_BITS-1:0]  frac;
  axis_t              axis_d, axis_q;

  assign twice  = $signed({2'b00, d_i, 1'b0}) - $signed({2'b00, dsize_i});
  assign prod_d = twice * $signed({1'b0, scale_i});

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    if (ssize_i == 9'd0) begin
      ssz = 9'd1;
    end else if (ssize_i > MAX_SZ) begin
      ssz = MAX_SZ;
    end else begin
      ssz = ssize_i;
    end
  end

  assign szs  = $signed({16'b0, ssz});
  assign v    = $signed({prod_q[39], prod_q}) + $signed({16'b0, ssz, 16'b0});
  assign fl   = {v[40], v[40:FRAC_BITS]};
  assign t    = v + 41'sd65536;
  assign tm   = t[40] ? 41'(-t) : 41'(t);
  assign nq   = t[40] ? -$signed({1'b0, tm[40:FRAC_BITS]}) : $signed({1'b0, tm[40:FRAC_BITS]});
  assign idx  = mode_i ? fl : nq;
  assign frac = v[FRAC_BITS-1 -: W_BITS];

  always_comb begin
    axis_d.idx   = idx[7:0];
    axis_d.oor   = (idx < 25'sd0) || (idx >= szs);
    axis_d.clamp = (idx == (szs - 25'sd1));
    if (mode_i) begin
      axis_d.w1 = WGT_ONE - {1'b0, frac};
      axis_d.w2 = frac;
    end else begin
      axis_d.w1 = WGT_ONE;
      axis_d.w2 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      axis_q <= axis_d;
    end
  end

  assign axis_o = axis_q;

endmodule

FILE: src/bir_bank.sv
// ----------------------------------------------------------------------------
// bir_bank
// One parity bank of the frame store: single port, registered read.
// ----------------------------------------------------------------------------
module bir_bank import bir_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic               re_i,
  input  logic [BANK_AW-1:0] addr_i,
  input  logic [31:0]        wdata_i,
  output logic [31:0]        rdata_o
);

  logic [31:0] mem [2**BANK_AW];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bir_lane.sv
// ----------------------------------------------------------------------------
// bir_lane
// One channel of the blend: horizontal pass, then vertical pass and scaling.
// ----------------------------------------------------------------------------
module bir_lane import bir_pkg::*; (
  input  logic              clk_i,
  input  logic              en4_i,
  input  logic              en5_i,
  input  logic [7:0]        p11_i,
  input  logic [7:0]        p12_i,
  input  logic [7:0]        p21_i,
  input  logic [7:0]        p22_i,
  input  logic [7:0]        wx1_i,
  input  logic [W_BITS-1:0] wx2_i,
  input  logic [7:0]        wy1_i,
  input  logic [W_BITS-1:0] wy2_i,
  output logic [7:0]        q_o
);

  logic [15:0]       top_d, bot_d, top_q, bot_q;
  logic [7:0]        wy1_q;
  logic [W_BITS-1:0] wy2_q;
  logic [23:0]       sum;
  logic [7:0]        q_q;

  assign top_d = ({8'b0, p11_i} * {8'b0, wx1_i}) + ({8'b0, p12_i} * {9'b0, wx2_i});
  assign bot_d = ({8'b0, p21_i} * {8'b0, wx1_i}) + ({8'b0, p22_i} * {9'b0, wx2_i});

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      top_q <= top_d;
      bot_q <= bot_d;
      wy1_q <= wy1_i;
      wy2_q <= wy2_i;
    end
  end

  assign sum = ({8'b0, top_q} * {16'b0, wy1_q}) + ({8'b0, bot_q} * {17'b0, wy2_q});

  always_ff @(posedge clk_i) begin
    if (en5_i) begin
      q_q <= sum[2*W_BITS +: 8];
    end
  end

  assign q_o = q_q;

endmodule

FILE: src/bilinear_image_resampler.sv
// ----------------------------------------------------------------------------
// bilinear_image_resampler
// Frame store plus nearest/bilinear resampling of destination pixels.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_ready_o is high, source writes and
// destination requests in any order; a request passes the input, multiply,
// index/bank-read and blend registers to the output. The rate is set by the
// frame store, split into four single-port banks by row and column parity
// so the four neighbors of a request are read in the same cycle. Each channel
// has its own blend lane; stages drain into empty slots when output stalls.
module bilinear_image_resampler import bir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  src_x_i,
  input  logic [7:0]  src_y_i,
  input  logic [31:0] pixel_in_i,
  input  logic [11:0] dst_x_i,
  input  logic [11:0] dst_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_out_o,
  output logic        out_of_range_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  logic [8:0]  src_w_q, src_h_q;
  logic [12:0] dst_w_q, dst_h_q;
  logic [23:0] scale_x_q, scale_y_q;
  logic        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= 9'd256;
      src_h_q   <= 9'd256;
      dst_w_q   <= 13'd256;
      dst_h_q   <= 13'd256;
      scale_x_q <= 24'd65536;
      scale_y_q <= 24'd65536;
      mode_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_WIDTH:  src_w_q   <= cfg_data_i[8:0];
        REG_SRC_HEIGHT: src_h_q   <= cfg_data_i[8:0];
        REG_DST_WIDTH:  dst_w_q   <= cfg_data_i[12:0];
        REG_DST_HEIGHT: dst_h_q   <= cfg_data_i[12:0];
        REG_SCALE_X:    scale_x_q <= cfg_data_i;
        REG_SCALE_Y:    scale_y_q <= cfg_data_i;
        REG_INTERP:     mode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic typ1_q, typ2_q;
  logic [7:0]  sx1_q, sy1_q, sx2_q, sy2_q;
  logic [31:0] pix1_q, pix2_q;
  logic        oor4_q, oor5_q;
  meta_t       meta_d, meta3_q;
  axis_t       ax_x, ax_y;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q && typ2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      typ1_q <= req_type_i;
      sx1_q  <= src_x_i;
      sy1_q  <= src_y_i;
      pix1_q <= pixel_in_i;
    end
    if (en2) begin
      typ2_q <= typ1_q;
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
      pix2_q <= pix1_q;
    end
    if (en3) begin
      meta3_q <= meta_d;
    end
    if (en4) begin
      oor4_q <= meta3_q.oor;
    end
    if (en5) begin
      oor5_q <= oor4_q;
    end
  end

  bir_axis u_axis_x (
    .clk_i   (clk_i),
    .en1_i   (en1),
    .en2_i   (en2),
    .d_i     (dst_x_i),
    .dsize_i (dst_w_q),
    .scale_i (scale_x_q),
    .ssize_i (src_w_q),
    .mode_i  (mode_q),
    .axis_o  (ax_x)
  );

  bir_axis u_axis_y (
    .clk_i   (clk_i),
    .en1_i   (en1),
    .en2_i   (en2),
    .d_i     (dst_y_i),
    .dsize_i (dst_h_q),
    .scale_i (scale_y_q),
    .ssize_i (src_h_q),
    .mode_i  (mode_q),
    .axis_o  (ax_y)
  );

  always_comb begin
    meta_d.ix0 = ax_x.idx[0];
    meta_d.iy0 = ax_y.idx[0];
    meta_d.clx = ax_x.clamp;
    meta_d.cly = ax_y.clamp;
    meta_d.oor = ax_x.oor || ax_y.oor;
    meta_d.wx1 = ax_x.w1;
    meta_d.wx2 = ax_x.w2;
    meta_d.wy1 = ax_y.w1;
    meta_d.wy2 = ax_y.w2;
  end

  // even half index is (i+1)/2, odd half is i/2
  logic [8:0]         ixp, iyp;
  logic [HALF_AW-1:0] col_even, col_odd, row_even, row_odd;
  logic [31:0]        bank_q [BANKS];

  assign ixp      = {1'b0, ax_x.idx} + 9'd1;
  assign iyp      = {1'b0, ax_y.idx} + 9'd1;
  assign col_even = ixp[HALF_AW:1];
  assign col_odd  = ax_x.idx[HALF_AW:1];
  assign row_even = iyp[HALF_AW:1];
  assign row_odd  = ax_y.idx[HALF_AW:1];

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    localparam logic [1:0] BID = 2'(b);
    logic               we, re;
    logic [BANK_AW-1:0] addr;
    assign we = en3 && v2_q && !typ2_q && (sy2_q[0] == BID[1]) && (sx2_q[0] == BID[0]);
    assign re = en3 && v2_q && typ2_q;
    always_comb begin
      if (!typ2_q) begin
        addr = {sy2_q[HALF_AW:1], sx2_q[HALF_AW:1]};
      end else begin
        addr = {(BID[1] ? row_odd : row_even), (BID[0] ? col_odd : col_even)};
      end
    end
    bir_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .re_i    (re),
      .addr_i  (addr),
      .wdata_i (pix2_q),
      .rdata_o (bank_q[b])
    );
  end

  logic [1:0]  b11, b12, b21, b22;
  logic [31:0] p11, p12, p21, p22;

  always_comb begin
    b11 = {meta3_q.iy0, meta3_q.ix0};
    b12 = {meta3_q.iy0, meta3_q.clx ? meta3_q.ix0 : !meta3_q.ix0};
    b21 = {meta3_q.cly ? meta3_q.iy0 : !meta3_q.iy0, meta3_q.ix0};
    b22 = {meta3_q.cly ? meta3_q.iy0 : !meta3_q.iy0,
           meta3_q.clx ? meta3_q.ix0 : !meta3_q.ix0};
    p11 = bank_q[b11];
    p12 = bank_q[b12];
    p21 = bank_q[b21];
    p22 = bank_q[b22];
  end

  logic [31:0] lanes;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    bir_lane u_lane (
      .clk_i (clk_i),
      .en4_i (en4),
      .en5_i (en5),
      .p11_i (p11[8*c +: 8]),
      .p12_i (p12[8*c +: 8]),
      .p21_i (p21[8*c +: 8]),
      .p22_i (p22[8*c +: 8]),
      .wx1_i (meta3_q.wx1),
      .wx2_i (meta3_q.wx2),
      .wy1_i (meta3_q.wy1),
      .wy2_i (meta3_q.wy2),
      .q_o   (lanes[8*c +: 8])
    );
  end

  assign out_valid_o    = v5_q;
  assign out_of_range_o = oor5_q;
  assign pixel_out_o    = oor5_q ? 32'd0 : lanes;

endmodule

FILE: src/bir_checker.sv
// ----------------------------------------------------------------------------
// bir_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module bir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pixel_out_o,
  input logic        out_of_range_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o))
    else $error("output word dropped or changed while stalled");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> pixel_out_o == 32'd0)
    else $error("out of range result carries nonzero pixel");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output");

endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pixel_out_o    (pixel_out_o),
  .out_of_range_o (out_of_range_o)
);

FILE: dv/bilinear_image_resampler_checker.sv
// ----------------------------------------------------------------------------
// bilinear_image_resampler_checker
// Watches the input, output and register ports of the resampler, keeps its
// own frame store and register copy, predicts each requested pixel and
// compares it against the block's output in order.
// ----------------------------------------------------------------------------
module bilinear_image_resampler_checker import bir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        req_type_i,
  input  logic [7:0]  src_x_i,
  input  logic [7:0]  src_y_i,
  input  logic [31:0] pixel_in_i,
  input  logic [11:0] dst_x_i,
  input  logic [11:0] dst_y_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] pixel_out_i,
  input  logic        out_of_range_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [31:0] pixel;
    logic        oor;
  } pixel_result_t;

  logic [31:0]   frame_mem [0:MAX_SRC_W*MAX_SRC_H-1];
  logic [8:0]    src_w, src_h;
  logic [12:0]   dst_w, dst_h;
  logic [23:0]   step_x, step_y;
  logic          bilinear;
  pixel_result_t expected_pixels [$];

  function automatic longint clamp_size(logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_SZ) return MAX_SZ;
    return v;
  endfunction

  function automatic longint map_pos(logic [11:0] d, logic [12:0] dsz, logic [23:0] s,
                                     longint ssz);
    return (2 * longint'(d) - longint'(dsz)) * longint'(s) + (ssz <<< 16);
  endfunction

  function automatic int weight(longint v, longint base);
    longint frac;
    frac = v - (base <<< FRAC_BITS);
    return 128 - int'((frac * 128) >>> FRAC_BITS);
  endfunction

  function automatic pixel_result_t resample(logic [11:0] dx, logic [11:0] dy);
    pixel_result_t r;
    longint sw, sh, vx, vy, ix, iy, x2, y2, tx, ty, top, bot;
    int wx1, wy1, wx2, wy2;
    logic [31:0] p11, p12, p21, p22;
    sw = clamp_size(src_w);
    sh = clamp_size(src_h);
    vx = map_pos(dx, dst_w, step_x, sw);
    vy = map_pos(dy, dst_h, step_y, sh);
    r.pixel = '0;
    r.oor = 1'b0;
    if (!bilinear) begin
      tx = vx + 65536;
      ty = vy + 65536;
      ix = (tx >= 0) ? (tx >>> FRAC_BITS) : -((-tx) >>> FRAC_BITS);
      iy = (ty >= 0) ? (ty >>> FRAC_BITS) : -((-ty) >>> FRAC_BITS);
    end else begin
      ix = vx >>> FRAC_BITS;
      iy = vy >>> FRAC_BITS;
    end
    if (ix < 0 || ix > sw - 1 || iy < 0 || iy > sh - 1) begin
      r.oor = 1'b1;
      return r;
    end
    if (!bilinear) begin
      r.pixel = frame_mem[iy * MAX_SRC_W + ix];
      return r;
    end
    x2 = (ix + 1 > sw - 1) ? sw - 1 : ix + 1;
    y2 = (iy + 1 > sh - 1) ? sh - 1 : iy + 1;
    wx1 = weight(vx, ix);
    wy1 = weight(vy, iy);
    wx2 = 128 - wx1;
    wy2 = 128 - wy1;
    p11 = frame_mem[iy * MAX_SRC_W + ix];
    p12 = frame_mem[iy * MAX_SRC_W + x2];
    p21 = frame_mem[y2 * MAX_SRC_W + ix];
    p22 = frame_mem[y2 * MAX_SRC_W + x2];
    for (int c = 0; c < CHANNELS; c++) begin
      top = p11[8*c +: 8] * wx1 + p12[8*c +: 8] * wx2;
      bot = p21[8*c +: 8] * wx1 + p22[8*c +: 8] * wx2;
      r.pixel[8*c +: 8] = 8'((top * wy1 + bot * wy2) / 16384);
    end
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      src_w    <= 9'd256;
      src_h    <= 9'd256;
      dst_w    <= 13'd256;
      dst_h    <= 13'd256;
      step_x   <= 24'd65536;
      step_y   <= 24'd65536;
      bilinear <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:  src_w    <= cfg_data_i[8:0];
          REG_SRC_HEIGHT: src_h    <= cfg_data_i[8:0];
          REG_DST_WIDTH:  dst_w    <= cfg_data_i[12:0];
          REG_DST_HEIGHT: dst_h    <= cfg_data_i[12:0];
          REG_SCALE_X:    step_x   <= cfg_data_i;
          REG_SCALE_Y:    step_y   <= cfg_data_i;
          REG_INTERP:     bilinear <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (!req_type_i) frame_mem[{src_y_i, src_x_i}] = pixel_in_i;
        else expected_pixels.push_back(resample(dst_x_i, dst_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("unexpected word: pixel %h oor %b",
                                           pixel_out_i, out_of_range_i);
        end else begin
          want = expected_pixels.pop_front();
          if (want.pixel !== pixel_out_i || want.oor !== out_of_range_i) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display("mismatch: pixel exp %h got %h, oor exp %b got %b",
                       want.pixel, pixel_out_i, want.oor, out_of_range_i);
          end
        end
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

FILE: dv/bilinear_image_resampler_test.sv
// ----------------------------------------------------------------------------
// bilinear_image_resampler_test
// Fills a corner of the frame store, then runs phases of register settings
// with directed and random source writes and destination requests under
// random stalls on both channels; requests that would read past the filled
// corner are not issued. A separate checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module bilinear_image_resampler_test;
  import bir_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int FILL  = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [7:0]  src_x = '0;
  logic [7:0]  src_y = '0;
  logic [31:0] pixel_in = '0;
  logic [11:0] dst_x = '0;
  logic [11:0] dst_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pixel_out;
  logic        out_of_range;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [23:0] cfg_data = '0;
  int          fail_count, pending;
  int          cycles = 0;
  bit          burst = 1'b0;
  bit          out_took = 1'b0;
  int          out_stall = 0;
  int          items = 0;
  int          cur_dw;
  logic [8:0]  shadow_sw = 9'd256;
  logic [8:0]  shadow_sh = 9'd256;
  logic [12:0] shadow_dw = 13'd256;
  logic [12:0] shadow_dh = 13'd256;
  logic [23:0] shadow_scx = 24'd65536;
  logic [23:0] shadow_scy = 24'd65536;
  logic        shadow_mode = 1'b1;

  always #4 clk_i = ~clk_i;

  bilinear_image_resampler uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .req_type_i(req_type),
    .src_x_i(src_x), .src_y_i(src_y), .pixel_in_i(pixel_in),
    .dst_x_i(dst_x), .dst_y_i(dst_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pixel_out_o(pixel_out), .out_of_range_o(out_of_range),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  bilinear_image_resampler_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .req_type_i(req_type),
    .src_x_i(src_x), .src_y_i(src_y), .pixel_in_i(pixel_in),
    .dst_x_i(dst_x), .dst_y_i(dst_y),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .pixel_out_i(pixel_out), .out_of_range_i(out_of_range),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_took <= out_valid && out_ready;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (out_took) out_stall = burst ? 0 : $urandom_range(0, 15);
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int draw_gap(bit sparse);
    if (burst) return 0;
    if (sparse && $urandom_range(0, 7) != 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic longint size_of(logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_SZ) return MAX_SZ;
    return v;
  endfunction

  function automatic longint index_of(logic [11:0] d, logic [12:0] dsz, logic [23:0] s,
                                      longint ssz);
    longint v;
    v = (2 * longint'(d) - longint'(dsz)) * longint'(s) + (ssz <<< 16);
    if (shadow_mode) return v >>> FRAC_BITS;
    v = v + 65536;
    return (v >= 0) ? (v >>> FRAC_BITS) : -((-v) >>> FRAC_BITS);
  endfunction

  // true when every neighbor the request reads lies in the filled corner
  function automatic bit covered(logic [11:0] dx, logic [11:0] dy);
    longint sw, sh, ix, iy, x2, y2;
    sw = size_of(shadow_sw);
    sh = size_of(shadow_sh);
    ix = index_of(dx, shadow_dw, shadow_scx, sw);
    iy = index_of(dy, shadow_dh, shadow_scy, sh);
    if (ix < 0 || ix > sw - 1 || iy < 0 || iy > sh - 1) return 1'b1;
    x2 = (ix + 1 > sw - 1) ? sw - 1 : ix + 1;
    y2 = (iy + 1 > sh - 1) ? sh - 1 : iy + 1;
    return (x2 < FILL) && (y2 < FILL);
  endfunction

  task automatic send_word(bit rt, logic [7:0] sx, logic [7:0] sy, logic [31:0] pix,
                           logic [11:0] dx, logic [11:0] dy, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    src_x    <= sx;
    src_y    <= sy;
    pixel_in <= pix;
    dst_x    <= dx;
    dst_y    <= dy;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic request(logic [11:0] dx, logic [11:0] dy);
    if (!covered(dx, dy)) return;
    send_word(1'b1, 8'($urandom), 8'($urandom), $urandom, dx, dy, draw_gap(1'b0));
    items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [23:0] val);
    case (idx)
      REG_SRC_WIDTH:  shadow_sw   = val[8:0];
      REG_SRC_HEIGHT: shadow_sh   = val[8:0];
      REG_DST_WIDTH:  shadow_dw   = val[12:0];
      REG_DST_HEIGHT: shadow_dh   = val[12:0];
      REG_SCALE_X:    shadow_scx  = val;
      REG_SCALE_Y:    shadow_scy  = val;
      REG_INTERP:     shadow_mode = val[0];
      default: ;
    endcase
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_phase();
    logic [8:0]  sw;
    logic [12:0] dw, dh;
    logic [23:0] sc;
    int sel, lim;
    sel = $urandom_range(0, 9);
    sw = (sel == 0) ? 9'd0 : (sel == 1) ? 9'd1 : (sel == 2) ? 9'd256 :
         (sel == 3) ? 9'($urandom_range(257, 511)) : 9'($urandom_range(2, FILL));
    write_reg(REG_SRC_WIDTH, {15'd0, sw});
    write_reg(REG_SRC_HEIGHT, ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                              24'($urandom_range(1, FILL)));
    sel = $urandom_range(0, 7);
    dw = (sel == 0) ? 13'd1 : (sel == 1) ? 13'd4096 : (sel == 2) ? 13'($urandom) :
         13'($urandom_range(1, 200));
    dh = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(1, 200));
    write_reg(REG_DST_WIDTH, {11'd0, dw});
    write_reg(REG_DST_HEIGHT, {11'd0, dh});
    sel = $urandom_range(0, 9);
    sc = (sel == 0) ? 24'd0 : (sel == 1) ? 24'hFFFFFF : (sel == 2) ? 24'($urandom) :
         24'($urandom_range(4096, 300000));
    write_reg(REG_SCALE_X, sc);
    write_reg(REG_SCALE_Y, ($urandom_range(0, 9) == 0) ? 24'($urandom) :
                           24'($urandom_range(4096, 300000)));
    write_reg(REG_INTERP, 24'($urandom));
    burst = ($urandom_range(0, 3) == 0);
    cur_dw = (dw == 0 || dw > 4096) ? 4096 : int'(dw);
    lim = (dh == 0 || dh > 4096) ? 4096 : int'(dh);
    repeat (60) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        send_word(1'b0, 8'($urandom), 8'($urandom), $urandom, 12'($urandom),
                  12'($urandom), draw_gap(1'b0));
        items++;
      end else if (sel == 1) begin
        request(12'($urandom), 12'($urandom));
      end else begin
        request(12'($urandom_range(0, cur_dw - 1)), 12'($urandom_range(0, lim - 1)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_reg(REG_SRC_WIDTH, 24'd256);
    write_reg(REG_SRC_HEIGHT, 24'd256);
    write_reg(REG_DST_WIDTH, 24'd256);
    write_reg(REG_DST_HEIGHT, 24'd256);
    write_reg(REG_SCALE_X, 24'd65536);
    write_reg(REG_SCALE_Y, 24'd65536);
    write_reg(REG_INTERP, 24'd1);
    // corner of the store filled first; requests never read past it
    for (int y = 0; y < FILL; y++)
      for (int x = 0; x < FILL; x++) begin
        send_word(1'b0, 8'(x), 8'(y), $urandom, 12'($urandom), 12'($urandom),
                  draw_gap(1'b1));
        items++;
      end
    send_word(1'b0, 8'd0, 8'd0, 32'hFFFFFFFF, '0, '0, 0);
    send_word(1'b0, 8'd255, 8'd255, 32'h00000000, '0, '0, 0);
    items += 2;
    request(12'd0, 12'd0);
    request(12'd4095, 12'd4095);
    request(12'd128, 12'd128);
    request(12'd255, 12'd0);
    request(12'd127, 12'd255);
    drain();
    // fractional bilinear, last-column clamp, nearest with negative position
    write_reg(REG_SRC_WIDTH, 24'd4);
    write_reg(REG_SRC_HEIGHT, 24'd4);
    write_reg(REG_DST_WIDTH, 24'd10);
    write_reg(REG_DST_HEIGHT, 24'd10);
    write_reg(REG_SCALE_X, 24'd29491);
    write_reg(REG_SCALE_Y, 24'd29491);
    for (int i = 0; i < 10; i++) request(12'(i), 12'(9 - i));
    drain();
    write_reg(REG_INTERP, 24'd0);
    for (int i = 0; i < 6; i++) request(12'(i), 12'(i));
    drain();
    while (items < 1350) random_phase();
    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
